>>> hdl/modexp_pkg.sv
package modexp_pkg;

  // Arithmetic word width; the ports carry words of this width
  localparam int unsigned WIDTH = 32;
  localparam int unsigned CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] bit_cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_EXP,
    ST_RED_BASE,
    ST_BIT,
    ST_MUL_RES,
    ST_MUL_SQ,
    ST_FIN
  } state_t;

  // Request to the shared modular multiplier: (a * b) mod m
  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
    word_t m;
  } mm_req_t;

  typedef struct packed {
    logic  done;
    word_t value;
  } mm_rsp_t;

endpackage

>>> hdl/modexp_mulmod.sv
module modexp_mulmod
  import modexp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  mm_req_t req,
  output mm_rsp_t rsp
);

  logic     busy_r, busy_nxt;
  logic     done_r, done_nxt;
  bit_cnt_t cnt_r, cnt_nxt;
  word_t    acc_r, acc_nxt;
  word_t    a_r, a_nxt;
  word_t    b_r, b_nxt;
  word_t    m_r, m_nxt;

  logic [WIDTH:0] dbl;
  word_t          dbl_red;
  logic [WIDTH:0] sum;
  word_t          sum_red;

  // One shift-and-add step: acc = (2*acc + bit*a) mod m, each half reduced once
  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, m_r}) ? WIDTH'(dbl - {1'b0, m_r}) : WIDTH'(dbl);
    sum     = {1'b0, dbl_red} + (b_r[WIDTH-1] ? {1'b0, a_r} : '0);
    sum_red = (sum >= {1'b0, m_r}) ? WIDTH'(sum - {1'b0, m_r}) : WIDTH'(sum);
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    m_nxt    = m_r;
    if (busy_r) begin
      acc_nxt = sum_red;
      b_nxt   = {b_r[WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(WIDTH - 1);
      acc_nxt  = '0;
      a_nxt    = req.a;
      b_nxt    = req.b;
      m_nxt    = req.m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    m_r   <= m_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.value = acc_r;

endmodule

>>> hdl/modular_exponentiation.sv
// Input transfer to result: a bad modulus or a zero base goes straight to the finish
//   state. Otherwise every modular product or reduction holds the shared unit in turn:
//   the exponent reduction in reduce mode, then the base reduction, then one product
//   per set exponent bit and one squaring per exponent bit below the top set bit.
// Throughput: one transfer at a time; in_stall is high until the result is
//   handed to the output register. Reset (rst_n, synchronous) clears reduce mode.
module modular_exponentiation
  import modexp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  // configuration
  input  logic  cfg_wr_en,
  input  logic  cfg_wr_data,
  // input channel
  input  logic  in_valid,
  output logic  in_stall,
  input  word_t in_base_value,
  input  word_t in_exponent,
  input  word_t in_modulus,
  // result channel
  output logic  out_valid,
  input  logic  out_stall,
  output word_t out_power_result,
  output logic  out_bad_modulus
);

  state_t  state_r, state_nxt;
  logic    mode_r;
  logic    issued_r, issued_nxt;

  // operand and working registers
  word_t   x_r, x_nxt;
  word_t   e_r, e_nxt;
  word_t   m_r, m_nxt;
  word_t   sq_r, sq_nxt;
  word_t   res_r, res_nxt;
  logic    bad_r, bad_nxt;

  // output register
  logic    out_valid_r, out_valid_nxt;
  word_t   out_res_r, out_res_nxt;
  logic    out_bad_r, out_bad_nxt;

  mm_req_t req;
  mm_rsp_t rsp;

  logic    in_xfer;
  logic    out_free;
  logic    bad_in;
  logic    computing;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  // zero modulus is never valid; reduce mode also needs a modulus of at least 2
  assign bad_in   = (in_modulus == '0) || (mode_r && (in_modulus < WIDTH'(2)));
  assign computing = (state_r == ST_RED_EXP) || (state_r == ST_RED_BASE) ||
                     (state_r == ST_MUL_RES) || (state_r == ST_MUL_SQ);

  // configuration register: the user must write it only while idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (bad_in || in_base_value == '0) begin
            state_nxt = ST_FIN;
          end else if (mode_r) begin
            state_nxt = ST_RED_EXP;
          end else begin
            state_nxt = ST_RED_BASE;
          end
        end
      end
      ST_RED_EXP: begin
        if (rsp.done) state_nxt = ST_RED_BASE;
      end
      ST_RED_BASE: begin
        if (rsp.done) state_nxt = ST_BIT;
      end
      ST_BIT: begin
        // scan the exponent from its low end; stop once no set bit remains
        if (e_r == '0) begin
          state_nxt = ST_FIN;
        end else if (e_r[0]) begin
          state_nxt = ST_MUL_RES;
        end else begin
          state_nxt = ST_MUL_SQ;
        end
      end
      ST_MUL_RES: begin
        // skip the final squaring when this was the top set bit
        if (rsp.done) begin
          state_nxt = (e_r[WIDTH-1:1] == '0) ? ST_FIN : ST_MUL_SQ;
        end
      end
      ST_MUL_SQ: begin
        if (rsp.done) state_nxt = ST_BIT;
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: the request to the shared unit
  always_comb begin
    req.start = computing && !issued_r;
    req.a     = res_r;
    req.b     = sq_r;
    req.m     = m_r;
    unique case (state_r)
      ST_RED_EXP: begin
        // exponent mod (m-1) as (1 * e) mod (m-1)
        req.a = WIDTH'(1);
        req.b = e_r;
        req.m = m_r - WIDTH'(1);
      end
      ST_RED_BASE: begin
        req.a = WIDTH'(1);
        req.b = x_r;
        req.m = m_r;
      end
      ST_MUL_RES: begin
        req.a = res_r;
        req.b = sq_r;
        req.m = m_r;
      end
      ST_MUL_SQ: begin
        req.a = sq_r;
        req.b = sq_r;
        req.m = m_r;
      end
      ST_IDLE, ST_BIT, ST_FIN: begin
        req.start = 1'b0;
      end
      default: req.start = 1'b0;
    endcase
  end

  // one request per compute state; drop the flag when the unit reports back
  always_comb begin
    issued_nxt = issued_r;
    if (rsp.done) begin
      issued_nxt = 1'b0;
    end else if (req.start) begin
      issued_nxt = 1'b1;
    end
  end

  // datapath next values
  always_comb begin
    x_nxt         = x_r;
    e_nxt         = e_r;
    m_nxt         = m_r;
    sq_nxt        = sq_r;
    res_nxt       = res_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_bad_nxt   = out_bad_r;

    // release the output register once its transfer completes
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          x_nxt   = in_base_value;
          e_nxt   = in_exponent;
          m_nxt   = in_modulus;
          bad_nxt = bad_in;
          res_nxt = '0;
        end
      end
      ST_RED_EXP: begin
        if (rsp.done) e_nxt = rsp.value;
      end
      ST_RED_BASE: begin
        if (rsp.done) begin
          sq_nxt  = rsp.value;
          // 1 mod m
          res_nxt = (m_r == WIDTH'(1)) ? '0 : WIDTH'(1);
        end
      end
      ST_MUL_RES: begin
        if (rsp.done) res_nxt = rsp.value;
      end
      ST_MUL_SQ: begin
        if (rsp.done) begin
          sq_nxt = rsp.value;
          e_nxt  = e_r >> 1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_bad_nxt   = bad_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r       <= x_nxt;
    e_r       <= e_nxt;
    m_r       <= m_nxt;
    sq_r      <= sq_nxt;
    res_r     <= res_nxt;
    bad_r     <= bad_nxt;
    out_res_r <= out_res_nxt;
    out_bad_r <= out_bad_nxt;
  end

  modexp_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_power_result = out_res_r;
  assign out_bad_modulus  = out_bad_r;

  // an accepted transfer holds the input side until the result is out
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a previous item is still in work");

  // the shared unit only answers a sequencer state that asked for it
  a_done_in_compute: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (issued_r && computing))
    else $error("multiplier response outside a compute state");

  // working values stay fully reduced
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BIT) |-> ((res_r < m_r) && (sq_r < m_r)))
    else $error("intermediate value not reduced below the modulus");

  // an invalid modulus always yields a zero result
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_modulus) |-> (out_power_result == '0))
    else $error("nonzero result reported with an invalid modulus");

endmodule

>>> verif/modular_exponentiation_tb.sv
`timescale 1ns / 100ps

module modular_exponentiation_tb;
  import modexp_pkg::*;

  localparam int unsigned STALL_LIMIT = 12000;  // cycles with no transfer on either side
  localparam int unsigned TAIL_CYCLES = 40;     // quiet time after the last result
  localparam int unsigned RANDOM_PHASES = 4;
  localparam int unsigned JOBS_PER_PHASE = 29;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic MODE_PLAIN = 1'b0;
  localparam logic MODE_FERMAT = 1'b1;

  // One exponentiation request. Where typed is set the expected result is
  // written out by hand; otherwise the software predictor supplies it.
  typedef struct packed {
    logic  fermat;
    word_t base_value;
    word_t exponent;
    word_t modulus;
    logic  typed;
    word_t typed_power;
    logic  typed_bad;
  } modexp_job_t;

  typedef struct packed {
    word_t power;
    logic  bad;
  } modexp_rsp_t;

  localparam int unsigned NUM_DIRECTED = 25;

  // Directed table: corner cases first in plain mode, then in Fermat mode.
  localparam modexp_job_t DIRECTED_JOBS [NUM_DIRECTED] = '{
    // zero base gives zero, even with a zero exponent
    '{MODE_PLAIN, 32'd0, 32'd0, 32'd5, 1'b1, 32'd0, 1'b0},
    // zero modulus is flagged whatever the base
    '{MODE_PLAIN, 32'd5, 32'd3, 32'd0, 1'b1, 32'd0, 1'b1},
    '{MODE_PLAIN, 32'd0, 32'd0, 32'd0, 1'b1, 32'd0, 1'b1},
    // zero exponent: 1 mod m, which collapses to 0 for a modulus of one
    '{MODE_PLAIN, 32'd7, 32'd0, 32'd1, 1'b1, 32'd0, 1'b0},
    '{MODE_PLAIN, 32'd7, 32'd0, 32'd13, 1'b1, 32'd1, 1'b0},
    // base a multiple of the modulus still counts as nonzero
    '{MODE_PLAIN, 32'd26, 32'd0, 32'd13, 1'b1, 32'd1, 1'b0},
    '{MODE_PLAIN, 32'd26, 32'd5, 32'd13, 1'b1, 32'd0, 1'b0},
    // all ones everywhere: base reduces to zero
    '{MODE_PLAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0},
    '{MODE_PLAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 1'b0, 32'd0, 1'b0},
    '{MODE_PLAIN, 32'd2, 32'd10, 32'd1000, 1'b1, 32'd24, 1'b0},
    '{MODE_PLAIN, 32'd3, 32'd1, 32'd7, 1'b1, 32'd3, 1'b0},
    '{MODE_PLAIN, 32'd1, 32'hFFFF_FFFF, 32'd2, 1'b1, 32'd1, 1'b0},
    '{MODE_PLAIN, 32'hFFFF_FFFE, 32'd2, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0},
    '{MODE_PLAIN, 32'd12345, 32'd65537, 32'h8000_0000, 1'b0, 32'd0, 1'b0},
    '{MODE_PLAIN, 32'd3, 32'd6, 32'd7, 1'b0, 32'd0, 1'b0},
    // Fermat mode: modulus below two is flagged, also with a zero base
    '{MODE_FERMAT, 32'd5, 32'd3, 32'd1, 1'b1, 32'd0, 1'b1},
    '{MODE_FERMAT, 32'd5, 32'd3, 32'd0, 1'b1, 32'd0, 1'b1},
    '{MODE_FERMAT, 32'd0, 32'd7, 32'd1, 1'b1, 32'd0, 1'b1},
    // exponent equal to m-1 folds to zero; just below it is left alone
    '{MODE_FERMAT, 32'd3, 32'd6, 32'd7, 1'b1, 32'd1, 1'b0},
    '{MODE_FERMAT, 32'd3, 32'd5, 32'd7, 1'b1, 32'd5, 1'b0},
    '{MODE_FERMAT, 32'd2, 32'hFFFF_FFFF, 32'd2, 1'b1, 32'd1, 1'b0},
    '{MODE_FERMAT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 1'b0, 32'd0, 1'b0},
    '{MODE_FERMAT, 32'd10, 32'd100, 32'd101, 1'b1, 32'd1, 1'b0},
    '{MODE_FERMAT, 32'd0, 32'd0, 32'd7, 1'b1, 32'd0, 1'b0},
    '{MODE_FERMAT, 32'h89AB_CDEF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0}
  };

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  cfg_wr_en = 1'b0;
  logic  cfg_wr_data = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  word_t in_base_value = '0;
  word_t in_exponent = '0;
  word_t in_modulus = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t out_power_result;
  logic  out_bad_modulus;

  modexp_job_t job_q [$];           // requests waiting to be offered
  modexp_rsp_t pending_powers [$];  // expected results, oldest first
  logic        fermat_mode = MODE_PLAIN;
  logic        no_idle = 1'b0;
  int unsigned fault_count = 0;
  int unsigned quiet_cycles = 0;

  modular_exponentiation u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_base_value    (in_base_value),
    .in_exponent      (in_exponent),
    .in_modulus       (in_modulus),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_power_result (out_power_result),
    .out_bad_modulus  (out_bad_modulus)
  );

  always #5 clk = ~clk;

  // Predict base^exponent mod modulus. Operands stay below the modulus, so a
  // 64-bit product never overflows and a plain remainder reduces it fully.
  function automatic modexp_rsp_t predict_power(word_t b, word_t e, word_t m, logic fermat);
    modexp_rsp_t rsp;
    logic [63:0] acc;
    logic [63:0] sq;
    word_t       ex;
    rsp.power = '0;
    rsp.bad = (m == 0) || (fermat && m < 2);
    if (rsp.bad || b == 0) return rsp;
    ex = e;
    // Fermat variant: fold the exponent once it reaches m-1
    if (fermat && e >= m - 1) ex = e % (m - 1);
    sq = 64'(b) % 64'(m);
    acc = 64'(1) % 64'(m);
    for (int i = 0; i < WIDTH; i++) begin
      if (ex[i]) acc = (acc * sq) % 64'(m);
      sq = (sq * sq) % 64'(m);
    end
    rsp.power = word_t'(acc);
    return rsp;
  endfunction

  // Hold back in roughly 16 of 100 draws, unless in the no-idle stretch
  function automatic logic draw_idle();
    return no_idle ? 1'b0 : ($urandom_range(99) < 16);
  endfunction

  // Random request, biased towards the interesting corners of the arithmetic
  function automatic modexp_job_t random_job();
    modexp_job_t job;
    int unsigned pick;
    job = '0;
    pick = $urandom_range(99);
    job.base_value = $urandom;
    job.exponent = $urandom;
    job.modulus = $urandom;
    if (pick < 8) begin
      job.base_value = '0;
    end else if (pick < 14) begin
      job.modulus = word_t'($urandom_range(1));
    end else if (pick < 40) begin
      job.modulus = word_t'($urandom_range(255, 2));
      if ($urandom_range(1)) job.exponent = word_t'($urandom_range(31));
    end else if (pick < 58) begin
      // exponents right around m-1 exercise the Fermat fold
      if (job.modulus < word_t'(2)) job.modulus = word_t'(2);
      job.exponent = job.modulus - word_t'(2) + word_t'($urandom_range(3));
    end else if (pick < 70) begin
      job.exponent = word_t'($urandom_range(31));
    end
    return job;
  endfunction

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  // Drop out only once nothing is queued, offered or outstanding
  task automatic wait_idle();
    do @(negedge clk);
    while (job_q.size() != 0 || in_valid || pending_powers.size() != 0);
  endtask

  // Write the mode register while the block is idle, keep the local copy in step
  task automatic write_mode(input logic mode);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    fermat_mode <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Sender: on every transfer, record what the block must answer, then offer
  // the next request or idle. A stalled request is held untouched.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (job_q[0].typed)
          pending_powers.push_back(modexp_rsp_t'{job_q[0].typed_power, job_q[0].typed_bad});
        else
          pending_powers.push_back(predict_power(job_q[0].base_value, job_q[0].exponent,
                                                 job_q[0].modulus, fermat_mode));
        void'(job_q.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (job_q.size() != 0 && !draw_idle()) begin
          in_valid <= 1'b1;
          in_base_value <= job_q[0].base_value;
          in_exponent <= job_q[0].exponent;
          in_modulus <= job_q[0].modulus;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare every transfer against the oldest expectation, then
  // stall at random for the next cycle.
  always @(posedge clk) begin
    modexp_rsp_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_powers.size() == 0) begin
          note_fault($sformatf("unexpected result: power_result %h bad_modulus %b",
                               out_power_result, out_bad_modulus));
        end else begin
          want = pending_powers.pop_front();
          if (out_power_result !== want.power)
            note_fault($sformatf("power_result mismatch: expected %h, got %h",
                                 want.power, out_power_result));
          if (out_bad_modulus !== want.bad)
            note_fault($sformatf("bad_modulus mismatch: expected %b, got %b",
                                 want.bad, out_bad_modulus));
        end
      end
      out_stall <= draw_idle();
    end
  end

  // Watchdog: count cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: drain and rewrite the mode wherever it changes
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      if (r == 0 || DIRECTED_JOBS[r].fermat != DIRECTED_JOBS[r-1].fermat) begin
        wait_idle();
        write_mode(DIRECTED_JOBS[r].fermat);
      end
      job_q.push_back(DIRECTED_JOBS[r]);
    end

    // Random phases alternate the mode; each starts from an idle block, so the
    // sender pauses until every expected result has come in. The third phase
    // runs with no idling on either side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      write_mode(p % 2 == 0 ? MODE_FERMAT : MODE_PLAIN);
      no_idle = (p == 2);
      repeat (JOBS_PER_PHASE) job_q.push_back(random_job());
    end

    wait_idle();
    no_idle = 1'b0;
    // leave room for any stray result to show up
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_powers.size() != 0)
      note_fault($sformatf("%0d results never arrived", pending_powers.size()));

    if (fault_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
